FILE: sv/xeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_pkg: shared types and constants
// Constants of the entity unescaper and the request type that moves from
// the front end through the queue to the UTF-8 back end.
// ----------------------------------------------------------------------------
package xeu_pkg;

	localparam int MAX_NAME_LEN = 5;
	localparam int LEN_W        = $clog2(MAX_NAME_LEN + 1);
	localparam int KEY_BYTES    = 4;   // longest keyword
	localparam int CP_W         = 21;  // code point width
	localparam int CP_ACC_W     = CP_W + 4;

	localparam logic [CP_W-1:0] CP_LIMIT = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_MAX_1 = 21'h00007F;
	localparam logic [CP_W-1:0] CP_MAX_2 = 21'h0007FF;
	localparam logic [CP_W-1:0] CP_MAX_3 = 21'h00FFFF;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// what the back end has to emit for one request
	typedef enum logic [1:0] {
		KIND_RAW,   // one byte as is (value[7:0])
		KIND_UTF8,  // code point, encoded to 1..4 bytes
		KIND_ERR    // single error result
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [CP_W-1:0] value;
	} item_t;

endpackage

FILE: sv/xeu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_front: input parser
// Tracks entity state, gathers the name, accumulates numeric references a
// digit at a time and pushes one request per input that yields output.
// ----------------------------------------------------------------------------
module xeu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 end_of_text,
	output logic                 push,
	output xeu_pkg::item_t       push_item,
	input  logic                 full
);

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;

	// exact keyword match on the first name bytes; {hit, value}
	function automatic logic [8:0] kw_lookup(
		input logic [xeu_pkg::LEN_W-1:0]              n,
		input logic [xeu_pkg::KEY_BYTES-1:0][7:0]     k
	);
		logic [8:0] r;
		r = 9'd0;
		if (int'(n) == 3 && k == {8'h00, "A", "x", "#"})      r = {1'b1, 8'h0A};
		else if (int'(n) == 4 && k == {"t", "o", "u", "q"})   r = {1'b1, 8'h22};
		else if (int'(n) == 3 && k == {8'h00, "p", "m", "a"}) r = {1'b1, 8'h26};
		else if (int'(n) == 4 && k == {"s", "o", "p", "a"})   r = {1'b1, 8'h27};
		else if (int'(n) == 2 && k == {16'h0000, "t", "l"})   r = {1'b1, 8'h3C};
		else if (int'(n) == 2 && k == {16'h0000, "t", "g"})   r = {1'b1, 8'h3E};
		return r;
	endfunction

	logic                                   in_entity_q, aborted_q;
	logic                                   is_num_q, hex_q, has_digit_q, bad_q;
	logic [xeu_pkg::LEN_W-1:0]              name_len_q;
	logic [xeu_pkg::KEY_BYTES-1:0][7:0]     key_q;
	logic [xeu_pkg::CP_W-1:0]               cp_q;

	logic                                   accept, is_amp, is_semi, is_x, x_pos;
	logic                                   dig_ok, dig_step, over, num_bad;
	logic                                   room, set_abort, kw_hit;
	logic [7:0]                             kw_val;
	logic [3:0]                             dig_val;
	logic [xeu_pkg::CP_ACC_W-1:0]           cp_ext, prod, cp_next;

	assign in_ready = !full;
	assign accept   = in_valid && !full;
	assign is_amp   = in_byte == CH_AMP;
	assign is_semi  = in_byte == CH_SEMI;
	assign is_x     = in_byte == "x" || in_byte == "X";
	assign room     = int'(name_len_q) < xeu_pkg::MAX_NAME_LEN;
	assign x_pos    = is_num_q && name_len_q == xeu_pkg::LEN_W'(1) && is_x;
	assign dig_step = is_num_q && !x_pos && !bad_q;
	assign {kw_hit, kw_val} = kw_lookup(name_len_q, key_q);
	assign num_bad  = bad_q || !has_digit_q;

	always_comb begin
		dig_ok  = 1'b0;
		dig_val = 4'd0;
		if (in_byte >= "0" && in_byte <= "9") begin
			dig_ok  = 1'b1;
			dig_val = 4'(in_byte - "0");
		end else if (hex_q && in_byte >= "a" && in_byte <= "f") begin
			dig_ok  = 1'b1;
			dig_val = 4'(in_byte - "a" + 8'd10);
		end else if (hex_q && in_byte >= "A" && in_byte <= "F") begin
			dig_ok  = 1'b1;
			dig_val = 4'(in_byte - "A" + 8'd10);
		end
	end

	// cp * radix + digit, radix 10 as (x << 3) + (x << 1)
	assign cp_ext  = {4'd0, cp_q};
	assign prod    = hex_q ? (cp_ext << 4) : ((cp_ext << 3) + (cp_ext << 1));
	assign cp_next = prod + {{(xeu_pkg::CP_ACC_W-4){1'b0}}, dig_val};
	assign over    = cp_next > {4'd0, xeu_pkg::CP_LIMIT};

	always_comb begin
		push            = 1'b0;
		set_abort       = 1'b0;
		push_item.kind  = xeu_pkg::KIND_RAW;
		push_item.value = {(xeu_pkg::CP_W-8)'(0), in_byte};
		if (accept && !aborted_q) begin
			if (!in_entity_q) begin
				push = !is_amp;
			end else if (is_semi) begin
				if (kw_hit) begin
					push            = 1'b1;
					push_item.value = {(xeu_pkg::CP_W-8)'(0), kw_val};
				end else if (name_len_q != '0 && is_num_q) begin
					push = 1'b1;
					if (num_bad) begin
						set_abort       = 1'b1;
						push_item.kind  = xeu_pkg::KIND_ERR;
						push_item.value = '0;
					end else begin
						push_item.kind  = xeu_pkg::KIND_UTF8;
						push_item.value = cp_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_entity_q <= 1'b0;
			aborted_q   <= 1'b0;
			is_num_q    <= 1'b0;
			hex_q       <= 1'b0;
			has_digit_q <= 1'b0;
			bad_q       <= 1'b0;
			name_len_q  <= '0;
			key_q       <= '0;
			cp_q        <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				in_entity_q <= 1'b0;
				aborted_q   <= 1'b0;
				name_len_q  <= '0;
				key_q       <= '0;
				is_num_q    <= 1'b0;
				hex_q       <= 1'b0;
				has_digit_q <= 1'b0;
				bad_q       <= 1'b0;
				cp_q        <= '0;
			end else if (!aborted_q) begin
				if (!in_entity_q) begin
					if (is_amp) begin
						in_entity_q <= 1'b1;
						name_len_q  <= '0;
						key_q       <= '0;
						is_num_q    <= 1'b0;
						hex_q       <= 1'b0;
						has_digit_q <= 1'b0;
						bad_q       <= 1'b0;
						cp_q        <= '0;
					end
				end else if (is_semi) begin
					in_entity_q <= 1'b0;
					aborted_q   <= set_abort;
				end else if (room) begin
					name_len_q <= name_len_q + 1'b1;
					if (int'(name_len_q) < xeu_pkg::KEY_BYTES)
						key_q[name_len_q[1:0]] <= in_byte;
					if (name_len_q == '0) begin
						is_num_q <= in_byte == CH_HASH;
					end else if (x_pos) begin
						hex_q <= 1'b1;
					end else if (dig_step) begin
						if (!dig_ok || over) begin
							bad_q <= 1'b1;
						end else begin
							cp_q        <= cp_next[xeu_pkg::CP_W-1:0];
							has_digit_q <= 1'b1;
						end
					end
				end else begin
					// name too long: drop the entity
					in_entity_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: sv/xeu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_queue: request queue
// Small flop FIFO between parser and encoder; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module xeu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  xeu_pkg::item_t  wr_item,
	output logic            full,
	input  logic            pop,
	output xeu_pkg::item_t  head,
	output logic            avail
);

	xeu_pkg::item_t                 mem_q [xeu_pkg::QUEUE_DEPTH];
	logic [xeu_pkg::QPTR_W-1:0]     wp_q, rp_q;
	logic [xeu_pkg::QCNT_W-1:0]     cnt_q;

	function automatic logic [xeu_pkg::QPTR_W-1:0] next_ptr(
		input logic [xeu_pkg::QPTR_W-1:0] p
	);
		return (p == xeu_pkg::QPTR_W'(xeu_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = cnt_q == xeu_pkg::QCNT_W'(xeu_pkg::QUEUE_DEPTH);
	assign avail = cnt_q != '0;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= next_ptr(wp_q);
			if (pop)
				rp_q <= next_ptr(rp_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: sv/xeu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_back: result encoder
// Expands the head request into 1..4 output bytes (UTF-8 for code points),
// one per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module xeu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  xeu_pkg::item_t  head,
	input  logic            avail,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            error
);

	logic [1:0]           idx_q, lm1;
	logic [3:0][7:0]      bytes;
	logic                 is_err, load, last;
	logic [7:0]           byte_sel;
	logic [xeu_pkg::CP_W-1:0] v;

	assign v = head.value;

	always_comb begin
		lm1    = 2'd0;
		is_err = 1'b0;
		bytes  = '0;
		unique case (head.kind)
			xeu_pkg::KIND_UTF8: begin
				if (v <= xeu_pkg::CP_MAX_1) begin
					bytes[0] = v[7:0];
				end else if (v <= xeu_pkg::CP_MAX_2) begin
					lm1      = 2'd1;
					bytes[0] = {3'b110, v[10:6]};
					bytes[1] = {2'b10, v[5:0]};
				end else if (v <= xeu_pkg::CP_MAX_3) begin
					lm1      = 2'd2;
					bytes[0] = {4'b1110, v[15:12]};
					bytes[1] = {2'b10, v[11:6]};
					bytes[2] = {2'b10, v[5:0]};
				end else begin
					lm1      = 2'd3;
					bytes[0] = {5'b11110, v[20:18]};
					bytes[1] = {2'b10, v[17:12]};
					bytes[2] = {2'b10, v[11:6]};
					bytes[3] = {2'b10, v[5:0]};
				end
			end
			xeu_pkg::KIND_ERR: begin
				is_err = 1'b1;
			end
			default: begin
				bytes[0] = v[7:0];
			end
		endcase
	end

	assign byte_sel = bytes[idx_q];
	assign last     = idx_q == lm1;
	assign load     = avail && (!out_valid || out_ready);
	assign pop      = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= 2'd0;
		end else begin
			if (load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (load)
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte    <= byte_sel;
			last_of_run <= last;
			error       <= is_err;
		end
	end

endmodule

FILE: sv/xml_entity_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_unescape_utf8: XML entity unescaper with UTF-8 output
// Byte stream in, unescaped byte stream out. Named entities quot, amp,
// apos, lt, gt, #xA and decimal/hex character references are decoded.
// ----------------------------------------------------------------------------
//  channel  dir  tdata            tlast         tuser
//  s_axis   in   in_byte[7:0]     end_of_text   -
//  m_axis   out  out_byte[7:0]    last_of_run   error
//
//  One input byte is taken per cycle unless the request queue is full. A
//  character reference produces up to four output bytes, emitted one per
//  cycle by the encoder unless the output stalls; the input keeps flowing
//  into a two-entry request queue while the encoder drains.
//  s_axis_tready drops only when the request queue is full.
//  Asynchronous reset clears all control state; the block is ready at once.
// ----------------------------------------------------------------------------
module xml_entity_unescape_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	// input text
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_text
	// unescaped output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast,   // last_of_run
	output logic        m_axis_tuser    // [0] error
);

	// front end -> queue
	logic            push;
	xeu_pkg::item_t  push_item;
	logic            full;

	// queue -> back end
	xeu_pkg::item_t  head;
	logic            avail;
	logic            pop;

	// Parser: entity state machine, name capture, digit accumulation.
	// Every request that yields output becomes one queue entry.
	xeu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.push        (push),
		.push_item   (push_item),
		.full        (full)
	);

	// Decouples the parser (byte/cycle unless full) from the multi-byte encoder.
	xeu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.avail   (avail)
	);

	// Encoder: walks the head entry byte by byte into the output register.
	xeu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.avail       (avail),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.last_of_run (m_axis_tlast),
		.error       (m_axis_tuser)
	);

endmodule

FILE: sv/xeu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_checker: port-level checks
// Watches the top-level ports of the unescaper; attached by bind.
// ----------------------------------------------------------------------------
module xeu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
			$stable(m_axis_tuser))
		else $error("output changed while stalled");

	// an error result is a lone zero byte
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00 && m_axis_tlast)
		else $error("malformed error result");

	// only multi-byte UTF-8 has bytes before the last of a run
	a_mid_utf8: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[7] && !m_axis_tuser)
		else $error("non-final byte is not UTF-8 multi-byte");

	// a continuation byte follows every accepted lead or middle byte
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
			m_axis_tdata[7:6] == 2'b10)
		else $error("missing UTF-8 continuation byte");

	// nothing valid while in reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind xml_entity_unescape_utf8 xeu_checker u_xeu_checker (.*);
